// ----- rtl/core/hrg_pkg.sv -----
// Package for the Householder reflector generator.
// Holds widths and the command and status types shared by controller and datapath.
package hrg_pkg;

   localparam int ElemWidth = 24;
   localparam int VWidth    = 32;
   localparam int TauWidth  = 32;
   localparam int BetaWidth = 27;
   localparam int SumWidth  = 52;
   localparam int RootWidth = 27;
   localparam int DivWidth  = 62;

   typedef struct packed {
      logic load_lead;
      logic load_tail;
      logic set_ovf;
      logic start_solve;
      logic start_div;
      logic first_out;
      logic clear_run;
   } hrg_cmd_type;

   typedef struct packed {
      logic root_done;
      logic tau_done;
      logic div_done;
      logic trivial;
   } hrg_status_type;

endpackage : hrg_pkg

// ----- rtl/core/hrg_if.sv -----
// Valid/ready channel interfaces for the reflector generator.
// Depends on hrg_pkg for field widths.
interface hrg_req_if;
   import hrg_pkg::*;
   logic valid;
   logic ready;
   logic signed [ElemWidth-1:0] element;
   logic is_last;
   modport source (output valid, element, is_last, input ready);
   modport sink (input valid, element, is_last, output ready);
endinterface : hrg_req_if

interface hrg_rsp_if;
   import hrg_pkg::*;
   logic valid;
   logic ready;
   logic signed [VWidth-1:0] v_value;
   logic [TauWidth-1:0] tau_value;
   logic signed [BetaWidth-1:0] beta_value;
   logic too_long;
   logic last_out;
   modport source (output valid, v_value, tau_value, beta_value, too_long, last_out,
                   input ready);
   modport sink (input valid, v_value, tau_value, beta_value, too_long, last_out,
                 output ready);
endinterface : hrg_rsp_if

// ----- rtl/core/hrg_datapath.sv -----
// Datapath: tail memory, square accumulator, bit-serial root and dividers.
// Depends on hrg_pkg; driven by hrg_ctrl through command signals.
module hrg_datapath #(
   parameter int MAX_LEN = 32,
   parameter int IDX_W   = 6
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  hrg_pkg::hrg_cmd_type                   cmd,
   input  logic signed [hrg_pkg::ElemWidth-1:0]  in_element,
   input  logic [IDX_W-1:0]                       wr_idx,
   input  logic [IDX_W-1:0]                       rd_idx,
   input  logic                                   rd_en,
   output hrg_pkg::hrg_status_type                status,
   output logic signed [hrg_pkg::VWidth-1:0]     v_value,
   output logic [hrg_pkg::TauWidth-1:0]          tau_value,
   output logic signed [hrg_pkg::BetaWidth-1:0]  beta_value
);
   import hrg_pkg::*;

   localparam int AW = (MAX_LEN > 2) ? $clog2(MAX_LEN - 1) : 1;

   logic signed [ElemWidth-1:0] mem [MAX_LEN-1];
   logic signed [ElemWidth-1:0] rd_data_ff;
   logic signed [ElemWidth-1:0] lead_ff;
   logic [SumWidth-1:0]         sum_ff;
   logic [ElemWidth-1:0]        in_mag;
   logic [2*ElemWidth-1:0]      in_sq;

   assign in_mag = in_element[ElemWidth-1] ? ElemWidth'(-in_element)
                                           : ElemWidth'(in_element);
   assign in_sq  = in_mag * in_mag;

   always_ff @(posedge clock) begin
      if (cmd.load_tail) begin
         mem[wr_idx[AW-1:0]] <= in_element;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_run) begin
         sum_ff  <= '0;
         lead_ff <= '0;
      end else begin
         if (cmd.load_lead) begin
            lead_ff <= in_element;
         end
         if (cmd.load_tail) begin
            sum_ff <= sum_ff + SumWidth'(in_sq);
         end
      end
   end

   // Integer square root, two radicand bits a cycle.
   logic [DivWidth-1:0]   rad_ff;
   logic [RootWidth:0]    root_ff;
   logic [RootWidth+2:0]  rem_ff;
   logic [5:0]            rcnt_ff;
   logic                  root_busy_ff;
   logic                  root_done_ff;
   logic [ElemWidth-1:0]  amag;
   logic [2*ElemWidth-1:0] amag_sq;
   logic [RootWidth+2:0]  trial;
   logic [RootWidth+2:0]  rem_sh;

   assign amag    = lead_ff[ElemWidth-1] ? ElemWidth'(-lead_ff) : ElemWidth'(lead_ff);
   assign amag_sq = amag * amag;
   assign rem_sh  = {rem_ff[RootWidth:0], rad_ff[DivWidth-1:DivWidth-2]};
   assign trial   = {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         root_busy_ff <= 1'b0;
         root_done_ff <= 1'b0;
      end else begin
         root_done_ff <= 1'b0;
         if (cmd.start_solve) begin
            root_busy_ff <= 1'b1;
            rcnt_ff      <= 6'd30;
         end else if (root_busy_ff) begin
            if (rcnt_ff == '0) begin
               root_busy_ff <= 1'b0;
               root_done_ff <= 1'b1;
            end
            rcnt_ff <= rcnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_solve) begin
         rad_ff  <= DivWidth'(amag_sq) + DivWidth'(sum_ff);
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (root_busy_ff) begin
         rad_ff <= {rad_ff[DivWidth-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[RootWidth-1:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[RootWidth-1:0], 1'b0};
         end
      end
   end

   // v0 magnitude, beta and v0^2 once the root is known.
   logic [RootWidth:0]      v0m_ff;
   logic signed [BetaWidth-1:0] beta_ff;
   logic                    trivial_ff;
   logic [DivWidth-1:0]     v0sq_ff;
   logic [2*RootWidth+1:0]  v0m_sq;

   assign v0m_sq = v0m_ff * v0m_ff;

   always_ff @(posedge clock) begin
      if (cmd.start_solve) begin
         trivial_ff <= (sum_ff == '0);
         beta_ff    <= BetaWidth'(lead_ff);
      end
      if (root_done_ff && !trivial_ff) begin
         v0m_ff  <= (RootWidth+1)'(amag) + root_ff;
         beta_ff <= lead_ff[ElemWidth-1] ? BetaWidth'(root_ff) : BetaWidth'(-root_ff);
      end
   end

   // Tau: restoring division of v0^2 by (sigma + v0^2), one quotient bit a cycle.
   logic [DivWidth:0]   tden_ff;
   logic [DivWidth:0]   trem_ff;
   logic [TauWidth-1:0] tq_ff;
   logic [5:0]          tcnt_ff;
   logic [1:0]          tph_ff;
   logic                tau_done_ff;
   logic [DivWidth+1:0] trem_sh;

   assign trem_sh = {trem_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         tph_ff      <= 2'd0;
         tau_done_ff <= 1'b0;
      end else begin
         tau_done_ff <= 1'b0;
         unique case (tph_ff)
            2'd0: begin
               if (root_done_ff) begin
                  tph_ff <= trivial_ff ? 2'd0 : 2'd1;
                  tau_done_ff <= trivial_ff;
               end
            end
            2'd1: begin
               v0sq_ff <= DivWidth'(v0m_sq);
               tph_ff  <= 2'd2;
            end
            2'd2: begin
               tden_ff <= (DivWidth+1)'(sum_ff) + (DivWidth+1)'(v0sq_ff);
               trem_ff <= (DivWidth+1)'(v0sq_ff);
               tq_ff   <= '0;
               tcnt_ff <= 6'd31;
               tph_ff  <= 2'd3;
            end
            2'd3: begin
               if (tcnt_ff == 6'd31 && trem_ff >= tden_ff) begin
                  trem_ff <= trem_ff - tden_ff;
                  tq_ff   <= TauWidth'(1);
                  tcnt_ff <= 6'd30;
               end else if (tcnt_ff == 6'd31) begin
                  tcnt_ff <= 6'd30;
               end else begin
                  if (trem_sh >= (DivWidth+2)'(tden_ff)) begin
                     trem_ff <= (DivWidth+1)'(trem_sh - (DivWidth+2)'(tden_ff));
                     tq_ff   <= {tq_ff[TauWidth-2:0], 1'b1};
                  end else begin
                     trem_ff <= trem_sh[DivWidth:0];
                     tq_ff   <= {tq_ff[TauWidth-2:0], 1'b0};
                  end
                  if (tcnt_ff == '0) begin
                     tph_ff      <= 2'd0;
                     tau_done_ff <= 1'b1;
                  end
                  tcnt_ff <= tcnt_ff - 6'd1;
               end
            end
            default: tph_ff <= 2'd0;
         endcase
      end
   end

   // Element division: |x| << 30 over |v0|, 54-bit dividend, one bit a cycle.
   localparam int XW = ElemWidth + 30;
   logic [XW-1:0]      dq_ff;
   logic [RootWidth+1:0] drem_ff;
   logic [5:0]         dcnt_ff;
   logic               dbusy_ff;
   logic               ddone_ff;
   logic               dneg_ff;
   logic               dzero_ff;
   logic [RootWidth+1:0] drem_sh;
   logic [ElemWidth-1:0] xmag;

   assign xmag    = rd_data_ff[ElemWidth-1] ? ElemWidth'(-rd_data_ff)
                                            : ElemWidth'(rd_data_ff);
   assign drem_sh = {drem_ff[RootWidth:0], dq_ff[XW-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
         ddone_ff <= 1'b0;
      end else begin
         ddone_ff <= 1'b0;
         if (cmd.start_div) begin
            dbusy_ff <= !cmd.first_out && !trivial_ff;
            ddone_ff <= cmd.first_out || trivial_ff;
            dcnt_ff  <= 6'(XW - 1);
         end else if (dbusy_ff) begin
            if (dcnt_ff == '0) begin
               dbusy_ff <= 1'b0;
               ddone_ff <= 1'b1;
            end
            dcnt_ff <= dcnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_div) begin
         dq_ff    <= {xmag, 30'd0};
         drem_ff  <= '0;
         dneg_ff  <= rd_data_ff[ElemWidth-1] != lead_ff[ElemWidth-1];
         dzero_ff <= trivial_ff;
         if (cmd.first_out) begin
            dq_ff    <= XW'(32'h4000_0000);
            dneg_ff  <= 1'b0;
            dzero_ff <= 1'b0;
         end
      end else if (dbusy_ff) begin
         if (drem_sh >= (RootWidth+2)'(v0m_ff)) begin
            drem_ff <= drem_sh - (RootWidth+2)'(v0m_ff);
            dq_ff   <= {dq_ff[XW-2:0], 1'b1};
         end else begin
            drem_ff <= drem_sh;
            dq_ff   <= {dq_ff[XW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (dzero_ff) begin
         v_value = '0;
      end else if (dneg_ff) begin
         v_value = VWidth'(-dq_ff[VWidth-1:0]);
      end else begin
         v_value = VWidth'(dq_ff[VWidth-1:0]);
      end
   end

   assign tau_value  = trivial_ff ? '0 : tq_ff;
   assign beta_value = beta_ff;

   assign status.root_done = root_done_ff;
   assign status.tau_done  = tau_done_ff;
   assign status.div_done  = ddone_ff;
   assign status.trivial   = trivial_ff;

endmodule : hrg_datapath

// ----- rtl/core/hrg_ctrl.sv -----
// Controller state machine for the reflector generator.
// Depends on hrg_pkg; commands hrg_datapath and runs both channels.
module hrg_ctrl #(
   parameter int MAX_LEN = 32,
   parameter int IDX_W   = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_is_last,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_too_long,
   output logic                    rsp_last_out,
   output hrg_pkg::hrg_cmd_type    cmd,
   input  hrg_pkg::hrg_status_type status,
   output logic [IDX_W-1:0]        wr_idx,
   output logic [IDX_W-1:0]        rd_idx,
   output logic                    rd_en
);
   import hrg_pkg::*;

   localparam logic [2:0] StLoad  = 3'd0;
   localparam logic [2:0] StRoot  = 3'd1;
   localparam logic [2:0] StTau   = 3'd2;
   localparam logic [2:0] StRead  = 3'd3;
   localparam logic [2:0] StDiv   = 3'd4;
   localparam logic [2:0] StEmit  = 3'd5;
   localparam logic [2:0] StStart = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] out_ff, out_in;
   logic             ovf_ff, ovf_in;
   logic             accept;

   assign req_ready    = (state_ff == StLoad);
   assign accept       = req_valid && req_ready;
   assign rsp_valid    = (state_ff == StEmit);
   assign rsp_too_long = ovf_ff;
   assign rsp_last_out = (out_ff + IDX_W'(1) == count_ff);
   assign wr_idx       = count_ff - IDX_W'(1);
   assign rd_idx       = out_ff - IDX_W'(1);
   assign rd_en        = (state_ff == StRead);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      out_in   = out_ff;
      ovf_in   = ovf_ff;
      cmd      = '0;
      unique case (state_ff)
         StLoad: begin
            if (accept) begin
               if (count_ff == '0) begin
                  cmd.load_lead = 1'b1;
                  count_in      = IDX_W'(1);
               end else if (count_ff < IDX_W'(MAX_LEN)) begin
                  cmd.load_tail = 1'b1;
                  count_in      = count_ff + IDX_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_is_last) begin
                  state_in = StRoot;
               end
            end
         end
         StRoot: begin
            // The lead element is registered by now, so the solve can start.
            cmd.start_solve = 1'b1;
            out_in          = '0;
            state_in        = StTau;
         end
         StTau: begin
            if (status.tau_done) begin
               state_in = StRead;
            end
         end
         StRead: begin
            state_in = StStart;
            cmd.start_div = 1'b0;
         end
         StStart: begin
            // The stored element has been read into the datapath register.
            cmd.start_div = 1'b1;
            state_in      = StDiv;
         end
         StDiv: begin
            if (status.div_done) begin
               state_in = StEmit;
            end
         end
         StEmit: begin
            if (rsp_ready) begin
               out_in = out_ff + IDX_W'(1);
               if (rsp_last_out) begin
                  cmd.clear_run = 1'b1;
                  count_in      = '0;
                  ovf_in        = 1'b0;
                  state_in      = StLoad;
               end else begin
                  state_in = StRead;
               end
            end
         end
         default: state_in = StLoad;
      endcase
      cmd.first_out = (out_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
         count_ff <= '0;
         out_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         out_ff   <= out_in;
         ovf_ff   <= ovf_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= IDX_W'(MAX_LEN)) else $error("element count beyond maximum");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("loading while emitting");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> out_ff < count_ff) else $error("emitting past vector end");

endmodule : hrg_ctrl

// ----- rtl/core/householder_reflector_gen_unit.sv -----
// Householder reflector generator, top level.
// Loads one vector of Q8.16 elements on req; after the element flagged
// is_last it computes mu = sqrt(alpha^2 + sigma), beta and tau, and then
// returns one rsp item per kept element carrying v, tau, beta and flags.
// While loading, an element is accepted whenever req is valid. Solving runs
// the bit-serial root and then the tau division (skipped when the tail is
// zero). Each result after the first passes through a bit-serial divider
// unless the tail is zero.
// One vector is worked on at a time; req_ready is low from the is_last item
// until the final result is taken. A stalled receiver simply holds the
// current result on rsp. Elements beyond MAX_LEN are dropped and reported
// through too_long. Reset empties the run; the tail memory needs no clear.
// Depends on hrg_pkg, hrg_if, hrg_ctrl and hrg_datapath.
module householder_reflector_gen_unit #(
   parameter int MAX_LEN = 32
) (
   input logic      clock,
   input logic      reset,
   hrg_req_if.sink  req,
   hrg_rsp_if.source rsp
);
   import hrg_pkg::*;

   localparam int IdxW = $clog2(MAX_LEN + 1);

   hrg_cmd_type    cmd;
   hrg_status_type status;
   logic [IdxW-1:0] wr_idx;
   logic [IdxW-1:0] rd_idx;
   logic            rd_en;

   hrg_ctrl #(.MAX_LEN(MAX_LEN), .IDX_W(IdxW)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req.valid),
      .req_is_last  (req.is_last),
      .req_ready    (req.ready),
      .rsp_valid    (rsp.valid),
      .rsp_ready    (rsp.ready),
      .rsp_too_long (rsp.too_long),
      .rsp_last_out (rsp.last_out),
      .cmd          (cmd),
      .status       (status),
      .wr_idx       (wr_idx),
      .rd_idx       (rd_idx),
      .rd_en        (rd_en)
   );

   hrg_datapath #(.MAX_LEN(MAX_LEN), .IDX_W(IdxW)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .in_element (req.element),
      .wr_idx     (wr_idx),
      .rd_idx     (rd_idx),
      .rd_en      (rd_en),
      .status     (status),
      .v_value    (rsp.v_value),
      .tau_value  (rsp.tau_value),
      .beta_value (rsp.beta_value)
   );

endmodule : householder_reflector_gen_unit

// ----- verif/tb_householder_reflector_gen_unit.sv -----
// Testbench for householder_reflector_gen_unit: drives vectors on req and checks
// every rsp item against a predictor of the reflector arithmetic in this file.
// Depends on hrg_pkg, hrg_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_householder_reflector_gen_unit;
   import hrg_pkg::*;

   localparam int MaxLen     = 32;
   localparam int CycleLimit = 2000000;
   localparam int ItemTotal  = 130;

   localparam int KindRandom   = 0;
   localparam int KindSmall    = 1;
   localparam int KindZeroTail = 2;
   localparam int KindExtreme  = 3;

   typedef struct packed {
      logic signed [ElemWidth-1:0] element;
      logic                        is_last;
   } elem_item_t;

   typedef struct packed {
      logic signed [VWidth-1:0]    v_value;
      logic [TauWidth-1:0]         tau_value;
      logic signed [BetaWidth-1:0] beta_value;
      logic                        too_long;
      logic                        last_out;
   } reflector_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hrg_req_if req ();
   hrg_rsp_if rsp ();

   householder_reflector_gen_unit #(.MAX_LEN(MaxLen)) u_dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   elem_item_t      pending_elems[$];
   reflector_item_t expected_refl[$];
   int              fail_count = 0;
   bit              stimulus_done = 1'b0;
   int              hold_off_cycles = 400;

   // Predictor state for the vector being loaded.
   logic signed [63:0] tail_elems[MaxLen];
   logic signed [63:0] lead_elem;
   logic [63:0]        sigma_acc;
   int                 kept_count;
   bit                 dropped_seen;

   function automatic logic [63:0] magnitude(input logic signed [63:0] a);
      return a < 0 ? -a : a;
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] n);
      logic [63:0] res;
      logic [63:0] bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] tau_fraction(input logic [63:0] num,
                                                input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = num / den;
      r = num % den;
      for (int k = 0; k < 31; k++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
         end
      end
      return q;
   endfunction

   task automatic clear_vector();
      lead_elem = 0;
      sigma_acc = 0;
      kept_count = 0;
      dropped_seen = 1'b0;
   endtask

   task automatic predict_reflector(input elem_item_t it);
      logic signed [63:0] x;
      logic signed [63:0] beta;
      logic signed [63:0] v0;
      logic [63:0]        am, mu, v0m, v0sq, tau, qm, v;
      bit                 trivial;
      reflector_item_t    r;
      x = it.element;
      if (kept_count == 0) begin
         lead_elem = x;
         kept_count = 1;
      end else if (kept_count < MaxLen) begin
         tail_elems[kept_count - 1] = x;
         sigma_acc = sigma_acc + magnitude(x) * magnitude(x);
         kept_count++;
      end else begin
         dropped_seen = 1'b1;
      end
      if (!it.is_last) return;
      trivial = (kept_count < 2) || (sigma_acc == 0);
      beta = lead_elem;
      tau = 0;
      v0 = 0;
      if (!trivial) begin
         am = magnitude(lead_elem);
         mu = root_floor(am * am + sigma_acc);
         v0m = am + mu;
         v0sq = v0m * v0m;
         beta = lead_elem >= 0 ? -$signed(mu) : $signed(mu);
         v0 = lead_elem >= 0 ? $signed(v0m) : -$signed(v0m);
         tau = tau_fraction(v0sq, sigma_acc + v0sq);
      end
      for (int i = 0; i < kept_count; i++) begin
         if (i == 0) begin
            v = 64'd1 << 30;
         end else if (trivial) begin
            v = 0;
         end else begin
            qm = (magnitude(tail_elems[i - 1]) << 30) / magnitude(v0);
            v = ((tail_elems[i - 1] < 0) != (v0 < 0)) ? -qm : qm;
         end
         r.v_value = v[VWidth-1:0];
         r.tau_value = tau[TauWidth-1:0];
         r.beta_value = beta[BetaWidth-1:0];
         r.too_long = dropped_seen;
         r.last_out = (i + 1 == kept_count);
         expected_refl.push_back(r);
      end
      clear_vector();
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   function automatic int gap_length();
      int p;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Driver: feeds pending items, with random gaps between them.
   int send_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         req.element <= '0;
         req.is_last <= 1'b0;
      end else if (!req.valid || req.ready) begin
         if (req.valid && req.ready) predict_reflector({req.element, req.is_last});
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req.valid <= 1'b0;
         end else if (pending_elems.size() > 0) begin
            elem_item_t it;
            it = pending_elems.pop_front();
            req.valid <= 1'b1;
            req.element <= it.element;
            req.is_last <= it.is_last;
            send_gap <= gap_length();
         end else begin
            req.valid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off after reset, so that the block fills and stalls req.
   always @(posedge clock) begin
      if (!reset && hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
      end
   end

   // Monitor: checks each accepted result and drives ready with random stalls.
   int stall_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            reflector_item_t got, want;
            got = {rsp.v_value, rsp.tau_value, rsp.beta_value, rsp.too_long,
                   rsp.last_out};
            if (expected_refl.size() == 0) begin
               report_mismatch("unexpected item", got.v_value, '0);
            end else begin
               want = expected_refl.pop_front();
               if (got.v_value !== want.v_value)
                  report_mismatch("v_value", got.v_value, want.v_value);
               if (got.tau_value !== want.tau_value)
                  report_mismatch("tau_value", got.tau_value, want.tau_value);
               if (got.beta_value !== want.beta_value)
                  report_mismatch("beta_value", got.beta_value, want.beta_value);
               if (got.too_long !== want.too_long)
                  report_mismatch("too_long", got.too_long, want.too_long);
               if (got.last_out !== want.last_out)
                  report_mismatch("last_out", got.last_out, want.last_out);
            end
         end
         if (hold_off_cycles > 0) begin
            rsp.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= 1'b1;
            stall_left <= gap_length();
         end
      end
   end

   task automatic queue_vector(input int len, input int kind);
      elem_item_t it;
      for (int i = 0; i < len; i++) begin
         case (kind)
            KindRandom: it.element = ElemWidth'($urandom);
            KindSmall: it.element = ElemWidth'($signed($urandom_range(0, 511)) - 256);
            KindZeroTail: it.element = (i == 0) ? ElemWidth'($urandom) : '0;
            default: it.element = $urandom_range(0, 1) ? 24'h800000 : 24'h7fffff;
         endcase
         it.is_last = (i == len - 1);
         pending_elems.push_back(it);
      end
   endtask

   int cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int sent;
      int len;
      clear_vector();
      // Directed: single element, extremes, zero tail, small values, overflowing vector.
      queue_vector(1, KindRandom);
      queue_vector(1, KindExtreme);
      queue_vector(2, KindExtreme);
      queue_vector(3, KindExtreme);
      queue_vector(3, KindZeroTail);
      queue_vector(2, KindSmall);
      queue_vector(MaxLen + 3, KindRandom);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      sent = pending_elems.size();
      while (sent < ItemTotal) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, MaxLen + 4)
                                           : $urandom_range(1, 6);
         if (len > ItemTotal - sent) len = ItemTotal - sent;
         queue_vector(len, $urandom_range(0, 9) < 7 ? KindRandom
                                                    : $urandom_range(KindSmall, KindExtreme));
         sent += len;
      end
      while (pending_elems.size() > 0 || req.valid || expected_refl.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule : tb_householder_reflector_gen_unit

// ----- filelist.f -----
rtl/core/hrg_pkg.sv
rtl/core/hrg_if.sv
rtl/core/hrg_datapath.sv
rtl/core/hrg_ctrl.sv
rtl/core/householder_reflector_gen_unit.sv
verif/tb_householder_reflector_gen_unit.sv
